// ===== rtl/mrpf_pkg.sv =====
`default_nettype none

package mrpf_pkg;

    // Field widths fixed by the reading format
    localparam int unsigned VAL_W  = 24;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned RATE_W = 20;
    localparam int unsigned CHK_W  = 25;

    // Rate test: rise * 3600 > max_rate * 10 * dt
    localparam int unsigned LHS_W     = 37;
    localparam int unsigned RHS_W     = 56;
    localparam int unsigned RATE10_W  = 24;
    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;

    // Reset values
    localparam logic [RATE10_W-1:0]   RATE10_RESET = 24'd50000;  // 5000 units/h, x10
    localparam logic signed [CHK_W-1:0] LAST_RESET = -25'sd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        VD_OK,
        VD_UNREAD,
        VD_FILLING,
        VD_WIN_FALL,
        VD_WIN_RATE,
        VD_LAST_FALL,
        VD_LAST_RATE
    } t_verdict;

endpackage

`default_nettype wire

// ===== rtl/meter_reading_plausibility_filter.sv =====
// An unreadable reading, or one taken while the window fills, goes from the input transfer
// through the finish state to the output registers; a full check first scans the window
// memory, one read per entry, through the two-stage check pipeline (pair difference, then
// rate multiply). The input stalls until the result is loaded into the output registers.
// Reset (synchronous, active low): window empty, last value -10, last time 0,
// max_rate 5000. Window memory contents are not cleared; unwritten entries are never used.
`default_nettype none

module meter_reading_plausibility_filter
    import mrpf_pkg::*;
#(
    parameter int unsigned WINDOW = 5
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    // configuration
    input  wire                       i_cfg_we,
    input  wire  [RATE_W-1:0]         i_cfg_data,
    // input channel
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  wire  [VAL_W-1:0]          i_reading,
    input  wire                       i_unreadable,
    input  wire  [TIME_W-1:0]         i_timestamp,
    // output channel
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output logic                      o_accepted,
    output logic [2:0]                o_verdict,
    output logic signed [CHK_W-1:0]   o_checked_value,
    output logic [TIME_W-1:0]         o_checked_time
);

    localparam int unsigned AW = $clog2(WINDOW);
    localparam int unsigned FW = $clog2(WINDOW + 1);
    localparam int unsigned SW = $clog2(WINDOW + 3);
    localparam int unsigned DW = VAL_W + TIME_W;

    // Window memory, circular, oldest entry at r_head once full
    logic [DW-1:0] r_mem [WINDOW];
    logic [DW-1:0] r_rd_data;

    // Control state
    t_state            r_state, n_state;
    t_verdict          r_verdict, n_verdict;
    logic [FW-1:0]     r_fill, n_fill;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [SW-1:0]     r_step, n_step;
    logic [RATE10_W-1:0] r_rate10;
    logic signed [CHK_W-1:0] r_last_v;
    logic [TIME_W-1:0] r_last_t;
    logic              r_out_valid;

    // Scan datapath
    logic [VAL_W-1:0]  r_prev_v, r_cand_v;
    logic [TIME_W-1:0] r_prev_t, r_cand_t;
    logic              r_a_valid, r_a_cand, r_a_fall;
    logic [CHK_W-1:0]  r_a_rise;
    logic [TIME_W:0]   r_a_dt;
    logic              r_m_valid, r_m_cand, r_m_fall, r_m_neg;
    logic [LHS_W-1:0]  r_m_lhs;
    logic [RHS_W-1:0]  r_m_rhs;

    // Output registers
    logic              r_out_accepted;
    t_verdict          r_out_verdict;
    logic signed [CHK_W-1:0] r_out_value;
    logic [TIME_W-1:0] r_out_time;

    logic              in_xfer;
    logic              full;
    logic [AW-1:0]     start_addr;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic              out_load;
    logic              last_load;
    logic              fin_now;
    logic              m_fast;
    t_verdict          m_verdict;
    logic [VAL_W-1:0]  rd_v;
    logic [TIME_W-1:0] rd_t;
    logic              a_is_cand;
    logic signed [CHK_W-1:0] a_prev_v, a_cur_v;
    logic [TIME_W-1:0] a_prev_t, a_cur_t;
    logic              n_a_valid, n_m_valid;
    logic [LHS_W-1:0]  n_m_lhs;
    logic [RHS_W-1:0]  n_m_rhs;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        begin
            r = (p == AW'(WINDOW - 1)) ? '0 : p + 1'b1;
            return r;
        end
    endfunction

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign full       = (r_fill == FW'(WINDOW));
    assign start_addr = full ? ptr_inc(r_head) : '0;
    assign rd_v       = r_rd_data[DW-1:TIME_W];
    assign rd_t       = r_rd_data[TIME_W-1:0];

    // Final stage: fall first, then rate
    assign m_fast = !r_m_neg && ({{(RHS_W-LHS_W){1'b0}}, r_m_lhs} > r_m_rhs);

    always_comb begin
        if (r_m_fall) begin
            m_verdict = r_m_cand ? VD_LAST_FALL : VD_WIN_FALL;
        end else if (m_fast) begin
            m_verdict = r_m_cand ? VD_LAST_RATE : VD_WIN_RATE;
        end else begin
            m_verdict = VD_OK;
        end
    end

    assign fin_now = r_m_valid && (r_m_fall || m_fast || r_m_cand);

    // Sequencer: next state and strobes
    always_comb begin
        n_state   = r_state;
        n_verdict = r_verdict;
        n_fill    = r_fill;
        n_head    = r_head;
        n_step    = r_step;
        n_rd_ptr  = ptr_inc(r_rd_ptr);
        rd_addr   = r_rd_ptr;
        mem_we    = 1'b0;
        mem_wa    = r_head;
        out_load  = 1'b0;
        last_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                rd_addr  = start_addr;
                n_rd_ptr = ptr_inc(start_addr);
                n_step   = '0;
                if (in_xfer) begin
                    if (i_unreadable) begin
                        n_verdict = VD_UNREAD;
                        n_state   = ST_FIN;
                    end else begin
                        mem_we = 1'b1;
                        if (full) begin
                            mem_wa = r_head;
                            n_head = ptr_inc(r_head);
                            n_state = ST_SCAN;
                        end else begin
                            mem_wa = r_fill[AW-1:0];
                            n_fill = r_fill + 1'b1;
                            if (r_fill == FW'(WINDOW - 1)) begin
                                n_state = ST_SCAN;
                            end else begin
                                n_verdict = VD_FILLING;
                                n_state   = ST_FIN;
                            end
                        end
                    end
                end
            end
            ST_SCAN: begin
                n_step = r_step + 1'b1;
                if (fin_now) begin
                    n_verdict = m_verdict;
                    last_load = (m_verdict == VD_OK);
                    n_state   = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Pair select: window neighbors, then candidate against last accepted
    assign a_is_cand = (r_step == SW'(WINDOW));
    assign a_prev_v  = a_is_cand ? r_last_v : $signed({1'b0, r_prev_v});
    assign a_cur_v   = a_is_cand ? $signed({1'b0, r_cand_v}) : $signed({1'b0, rd_v});
    assign a_prev_t  = a_is_cand ? r_last_t : r_prev_t;
    assign a_cur_t   = a_is_cand ? r_cand_t : rd_t;

    assign n_a_valid = (r_state == ST_SCAN) && !fin_now && (r_step != '0)
                       && (r_step <= SW'(WINDOW));
    assign n_m_valid = (r_state == ST_SCAN) && !fin_now && r_a_valid;

    // Multiply stage
    assign n_m_lhs = r_a_rise * SEC_PER_HOUR;
    assign n_m_rhs = r_rate10 * r_a_dt[TIME_W-1:0];

    // Window memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= {i_reading, i_timestamp};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_verdict   <= VD_OK;
            r_fill      <= '0;
            r_head      <= '0;
            r_rd_ptr    <= '0;
            r_step      <= '0;
            r_rate10    <= RATE10_RESET;
            r_last_v    <= LAST_RESET;
            r_last_t    <= '0;
            r_out_valid <= 1'b0;
            r_a_valid   <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_verdict <= n_verdict;
            r_fill    <= n_fill;
            r_head    <= n_head;
            r_rd_ptr  <= n_rd_ptr;
            r_step    <= n_step;
            r_a_valid <= n_a_valid;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                r_rate10 <= ({4'b0, i_cfg_data} << 3) + ({4'b0, i_cfg_data} << 1);
            end
            if (last_load) begin
                r_last_v <= $signed({1'b0, r_cand_v});
                r_last_t <= r_cand_t;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && r_step < SW'(WINDOW)) begin
            r_prev_v <= rd_v;
            r_prev_t <= rd_t;
        end
        if (r_state == ST_SCAN && r_step == SW'(WINDOW / 2)) begin
            r_cand_v <= rd_v;
            r_cand_t <= rd_t;
        end
        r_a_cand <= a_is_cand;
        r_a_fall <= (a_cur_v < a_prev_v);
        r_a_rise <= a_cur_v - a_prev_v;
        r_a_dt   <= {1'b0, a_cur_t} - {1'b0, a_prev_t};
        r_m_cand <= r_a_cand;
        r_m_fall <= r_a_fall;
        r_m_neg  <= r_a_dt[TIME_W];
        r_m_lhs  <= n_m_lhs;
        r_m_rhs  <= n_m_rhs;
        if (out_load) begin
            r_out_accepted <= (r_verdict == VD_OK);
            r_out_verdict  <= r_verdict;
            r_out_value    <= r_last_v;
            r_out_time     <= r_last_t;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_out_accepted;
    assign o_verdict       = r_out_verdict;
    assign o_checked_value = r_out_value;
    assign o_checked_time  = r_out_time;

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(WINDOW))
        else $error("fill count beyond window depth");

    a_scan_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> full)
        else $error("scan started on a partial window");

    a_unread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_unreadable) |=>
            (r_state == ST_FIN && r_verdict == VD_UNREAD && $stable(r_fill)))
        else $error("unreadable reading changed the window");

    a_pipe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid || r_m_valid) |-> (r_state == ST_SCAN))
        else $error("check pipeline busy outside scan");

endmodule

`default_nettype wire
